// ===== sv/rwsp_pkg.sv =====
package rwsp_pkg;

    // Block constants.
    localparam int TILE_SIZE      = 90;
    localparam int DIST_FRAC_BITS = 8;

    // Field widths.
    localparam int CRD_W  = 16;
    localparam int ANG_W  = 16;
    localparam int SH_W   = 12;
    localparam int DIST_W = 16;
    localparam int H_W    = 20;
    localparam int ROW_W  = 12;

    // Angle units: 1/64 degree.
    localparam int FULL_TURN    = 23040;
    localparam int HALF_TURN    = 11520;
    localparam int QUARTER_TURN = 5760;
    localparam int A_W          = 13;

    // Square root of (dx^2 + dy^2) << 16, two radicand bits per cell.
    localparam int SUM_W    = 2 * CRD_W + 1;
    localparam int SQ_IN_W  = SUM_W + 17;
    localparam int ROOT_W   = SQ_IN_W / 2;
    localparam int SQ_CELLS = ROOT_W;

    // Tile distance: floor((root << DIST_FRAC_BITS) / (TILE_SIZE * 256)).
    localparam longint E_DIV = longint'(TILE_SIZE) * 256;
    localparam int     X_W   = ROOT_W + DIST_FRAC_BITS;
    localparam int     E_W   = $clog2(((64'(1) << X_W) - 1) / E_DIV + 1);
    localparam longint E_M   = (64'(1) << X_W) / E_DIV;

    // Angle to Q30 radians: t = floor(a * PI_Q30 / HALF_TURN).
    localparam longint PI_Q30 = 64'd3373259426;
    localparam longint ANG_Q  = PI_Q30 / HALF_TURN;
    localparam longint ANG_R  = PI_Q30 % HALF_TURN;
    localparam int     AQ_W   = 31;
    localparam int     AR_W   = 26;
    localparam int     ANG_S  = 40;
    localparam longint ANG_M  = ((64'(1) << ANG_S) + HALF_TURN - 1) / HALF_TURN;
    localparam int     ANGM_W = 27;
    localparam int     T_W    = 31;

    // Cosine series in Q30.
    localparam int     R_W       = 31;
    localparam int     T2_W      = 32;
    localparam longint ONE_Q30   = 64'(1) << 30;
    localparam int     COS_CELLS = 5;
    localparam int     COS_DIVS [COS_CELLS] = '{90, 56, 30, 12, 2};

    // Slice height divider.
    localparam int NUM_W = SH_W + DIST_FRAC_BITS;

    typedef struct packed {
        logic [CRD_W-1:0]        viewer_x;
        logic [CRD_W-1:0]        viewer_y;
        logic [CRD_W-1:0]        hit_x;
        logic [CRD_W-1:0]        hit_y;
        logic signed [ANG_W-1:0] column_angle;
        logic signed [ANG_W-1:0] view_angle;
    } t_item;

    typedef struct packed {
        logic [DIST_W-1:0] corrected_distance;
        logic [H_W-1:0]    slice_height;
        logic [ROW_W-1:0]  top_row;
        logic [ROW_W-1:0]  bottom_row;
    } t_result;

    typedef struct packed {
        logic           neg;
        logic [A_W-1:0] ang;
    } t_ang;

    typedef struct packed {
        logic            neg;
        logic [E_W-1:0]  e;
        logic [T2_W-1:0] t2;
    } t_cos_side;

endpackage

// ===== sv/rwsp_stream_if.sv =====
interface rwsp_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rwsp_sqrt_cell.sv =====
module rwsp_sqrt_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [rwsp_pkg::SQ_IN_W-1:0]  i_rad,
    input  logic [rwsp_pkg::ROOT_W-1:0]   i_rem,
    input  logic [rwsp_pkg::ROOT_W-1:0]   i_root,
    input  rwsp_pkg::t_ang                i_side,
    output logic                          o_valid,
    output logic [rwsp_pkg::SQ_IN_W-1:0]  o_rad,
    output logic [rwsp_pkg::ROOT_W-1:0]   o_rem,
    output logic [rwsp_pkg::ROOT_W-1:0]   o_root,
    output rwsp_pkg::t_ang                o_side
);
    import rwsp_pkg::*;

    logic [ROOT_W+1:0] n_rem_sh;
    logic [ROOT_W+1:0] n_trial;
    logic              n_fit;
    logic [ROOT_W+1:0] n_rem;

    logic                r_valid;
    logic [SQ_IN_W-1:0]  r_rad;
    logic [ROOT_W-1:0]   r_rem;
    logic [ROOT_W-1:0]   r_root;
    t_ang                r_side;

    // Bring down the next two radicand bits and try the new root bit.
    assign n_rem_sh = {i_rem, i_rad[SQ_IN_W-1 -: 2]};
    assign n_trial  = {i_root, 2'b01};
    assign n_fit    = (n_rem_sh >= n_trial);
    assign n_rem    = n_fit ? (n_rem_sh - n_trial) : n_rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= i_rad << 2;
            r_rem  <= n_rem[ROOT_W-1:0];
            r_root <= {i_root[ROOT_W-2:0], n_fit};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;
endmodule

// ===== sv/rwsp_cos_cell.sv =====
module rwsp_cos_cell #(
    parameter int K = 90
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [rwsp_pkg::R_W-1:0]   i_r,
    input  rwsp_pkg::t_cos_side        i_side,
    output logic                       o_valid,
    output logic [rwsp_pkg::R_W-1:0]   o_r,
    output rwsp_pkg::t_cos_side        o_side
);
    import rwsp_pkg::*;

    // Reciprocal of K; the quotient it gives is short by at most one.
    localparam logic [31:0] RECIP = 32'((64'(1) << 32) / K);

    logic [R_W+T2_W-1:0] n_prod;
    logic [31:0]         n_q0;
    logic [31:0]         n_rem;
    logic [32:0]         n_q;
    logic [R_W-1:0]      n_r;

    logic [2:0]  r_valid;
    logic [31:0] r_x1;
    logic [31:0] r_x2;
    logic [63:0] r_p2;
    logic [R_W-1:0] r_r3;
    t_cos_side   r_side1;
    t_cos_side   r_side2;
    t_cos_side   r_side3;

    assign n_prod = R_W'(i_r) * i_side.t2;
    assign n_q0   = r_p2[63:32];
    assign n_rem  = r_x2 - 32'(n_q0 * 32'(K));
    assign n_q    = (n_rem >= 32'(K)) ? (33'(n_q0) + 33'd1) : 33'(n_q0);
    // One minus the term, clamped at zero.
    assign n_r    = (n_q >= 33'(ONE_Q30)) ? '0 : R_W'(33'(ONE_Q30) - n_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1    <= n_prod[61:30];
            r_side1 <= i_side;
            r_p2    <= r_x1 * RECIP;
            r_x2    <= r_x1;
            r_side2 <= r_side1;
            r_r3    <= n_r;
            r_side3 <= r_side2;
        end
    end

    assign o_valid = r_valid[2];
    assign o_r     = r_r3;
    assign o_side  = r_side3;
endmodule

// ===== sv/rwsp_div_cell.sv =====
module rwsp_div_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [rwsp_pkg::NUM_W-1:0]   i_num,
    input  logic [rwsp_pkg::DIST_W-1:0]  i_rem,
    input  logic [rwsp_pkg::NUM_W-1:0]   i_q,
    input  logic [rwsp_pkg::DIST_W-1:0]  i_d,
    output logic                         o_valid,
    output logic [rwsp_pkg::NUM_W-1:0]   o_num,
    output logic [rwsp_pkg::DIST_W-1:0]  o_rem,
    output logic [rwsp_pkg::NUM_W-1:0]   o_q,
    output logic [rwsp_pkg::DIST_W-1:0]  o_d
);
    import rwsp_pkg::*;

    logic [DIST_W:0] n_rem_sh;
    logic            n_fit;
    logic [DIST_W:0] n_rem;

    logic              r_valid;
    logic [NUM_W-1:0]  r_num;
    logic [DIST_W-1:0] r_rem;
    logic [NUM_W-1:0]  r_q;
    logic [DIST_W-1:0] r_d;

    // Restoring division, one quotient bit per cell.
    assign n_rem_sh = {i_rem, i_num[NUM_W-1]};
    assign n_fit    = (n_rem_sh >= {1'b0, i_d});
    assign n_rem    = n_fit ? (n_rem_sh - {1'b0, i_d}) : n_rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= i_num << 1;
            r_rem <= n_rem[DIST_W-1:0];
            r_q   <= {i_q[NUM_W-2:0], n_fit};
            r_d   <= i_d;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_q     = r_q;
    assign o_d     = r_d;
endmodule

// ===== sv/raycast_wall_slice_projection.sv =====
// Wall column projection for a ray caster. Each transfer on i_item carries one screen
// column: the viewer and hit positions in world units and the ray and facing angles in
// 1/64 degree. The block returns one result per column on o_result: the fisheye-corrected
// distance in tiles (Q8.8, at least one LSB, saturating), the slice height
// (screen_height * 256 / distance) and the first and last wall rows clamped to the screen.
// The block takes one column per clock cycle while its output skid entry is free. The cell
// chains: 25 square root cells (two radicand bits each), five cosine series cells of three
// stages, and 20 divider cells (one quotient bit each), plus stages 1-3, E1-E4 and D1-D2.
// A two-entry output buffer lets the pipeline keep taking columns while one result waits.
// screen_height is written on i_cfg and must only change while no column is in flight.
module raycast_wall_slice_projection (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rwsp_stream_if.sink   i_item,
    rwsp_stream_if.sink   i_cfg,
    rwsp_stream_if.source o_result
);
    import rwsp_pkg::*;

    logic en;

    // Configuration register.
    logic [SH_W-1:0] r_screen_height;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_height <= SH_W'(1080);
        end else if (i_cfg.valid) begin
            r_screen_height <= i_cfg.data[SH_W-1:0];
        end
    end

    // The pipeline moves whenever the output skid entry is free.
    assign i_item.ready = en;

    // Stage 1: coordinate differences and raw angle difference.
    logic                  r1_v;
    logic [CRD_W-1:0]      r1_adx;
    logic [CRD_W-1:0]      r1_ady;
    logic signed [ANG_W:0] r1_diff;
    t_item                 in_d;

    assign in_d = i_item.data;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_adx  <= (in_d.viewer_x >= in_d.hit_x) ? (in_d.viewer_x - in_d.hit_x)
                                                     : (in_d.hit_x - in_d.viewer_x);
            r1_ady  <= (in_d.viewer_y >= in_d.hit_y) ? (in_d.viewer_y - in_d.hit_y)
                                                     : (in_d.hit_y - in_d.viewer_y);
            r1_diff <= (ANG_W+1)'(in_d.column_angle) - (ANG_W+1)'(in_d.view_angle);
        end
    end

    // Stage 2: squares, and the angle difference reduced into one full turn.
    logic                 r2_v;
    logic [2*CRD_W-1:0]   r2_sqx;
    logic [2*CRD_W-1:0]   r2_sqy;
    logic [A_W+1:0]       r2_m;
    logic [17:0]          n_raw;
    logic [17:0]          n_off;
    logic [17:0]          n_mod;

    // The offset difference lies below six full turns, so the whole turns to remove
    // are found by comparing against each multiple side by side.
    assign n_raw = 18'($signed({r1_diff[ANG_W], r1_diff}) + 18'sd69120);

    always_comb begin
        n_off = '0;
        for (int k = 1; k <= 5; k++) begin
            if (n_raw >= 18'(k * FULL_TURN)) begin
                n_off = 18'(k * FULL_TURN);
            end
        end
        n_mod = n_raw - n_off;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sqx <= r1_adx * r1_adx;
            r2_sqy <= r1_ady * r1_ady;
            r2_m   <= n_mod[A_W+1:0];
        end
    end

    // Stage 3: radicand, and the angle folded into one quarter turn with a sign.
    logic               r3_v;
    logic [SQ_IN_W-1:0] r3_rad;
    t_ang               r3_side;
    t_ang               n_fold;

    always_comb begin
        priority if (r2_m <= (A_W+2)'(QUARTER_TURN)) begin
            n_fold.neg = 1'b0;
            n_fold.ang = A_W'(r2_m);
        end else if (r2_m < (A_W+2)'(HALF_TURN)) begin
            n_fold.neg = 1'b1;
            n_fold.ang = A_W'((A_W+2)'(HALF_TURN) - r2_m);
        end else if (r2_m <= (A_W+2)'(HALF_TURN + QUARTER_TURN)) begin
            n_fold.neg = 1'b1;
            n_fold.ang = A_W'(r2_m - (A_W+2)'(HALF_TURN));
        end else begin
            n_fold.neg = 1'b0;
            n_fold.ang = A_W'((A_W+2)'(FULL_TURN) - r2_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_rad  <= SQ_IN_W'({SUM_W'(r2_sqx) + SUM_W'(r2_sqy), 16'h0000});
            r3_side <= n_fold;
        end
    end

    // Square root chain.
    logic               sq_v    [SQ_CELLS+1];
    logic [SQ_IN_W-1:0] sq_rad  [SQ_CELLS+1];
    logic [ROOT_W-1:0]  sq_rem  [SQ_CELLS+1];
    logic [ROOT_W-1:0]  sq_root [SQ_CELLS+1];
    t_ang               sq_side [SQ_CELLS+1];

    assign sq_v[0]    = r3_v;
    assign sq_rad[0]  = r3_rad;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = r3_side;

    for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sqrt
        rwsp_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[g]),
            .i_rad   (sq_rad[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_side  (sq_side[g]),
            .o_valid (sq_v[g+1]),
            .o_rad   (sq_rad[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_side  (sq_side[g+1])
        );
    end

    // E1: reciprocal product for the tile division; split angle products.
    logic               re1_v;
    logic [X_W-1:0]     re1_x;
    logic [X_W+E_W-1:0] re1_p;
    logic [AQ_W-1:0]    re1_aq;
    logic [AR_W-1:0]    re1_ar;
    logic               re1_neg;
    logic [X_W-1:0]     n_x;

    assign n_x = {sq_root[SQ_CELLS], DIST_FRAC_BITS'(0)};

    always_ff @(posedge i_clk) begin
        if (en) begin
            re1_x   <= n_x;
            re1_p   <= n_x * E_W'(E_M);
            re1_aq  <= AQ_W'(sq_side[SQ_CELLS].ang) * AQ_W'(ANG_Q);
            re1_ar  <= AR_W'(sq_side[SQ_CELLS].ang) * AR_W'(ANG_R);
            re1_neg <= sq_side[SQ_CELLS].neg;
        end
    end

    // E2: correct the tile quotient by one where needed.
    logic                     re2_v;
    logic [E_W-1:0]           re2_e;
    logic [AR_W+ANGM_W-1:0]   re2_tp;
    logic [AQ_W-1:0]          re2_aq;
    logic                     re2_neg;
    logic [E_W-1:0]           n_q0;
    logic [X_W-1:0]           n_erem;

    assign n_q0   = re1_p[X_W+E_W-1:X_W];
    assign n_erem = re1_x - X_W'(n_q0 * X_W'(E_DIV));

    always_ff @(posedge i_clk) begin
        if (en) begin
            re2_e   <= (n_erem >= X_W'(E_DIV)) ? (n_q0 + E_W'(1)) : n_q0;
            re2_tp  <= re1_ar * ANGM_W'(ANG_M);
            re2_aq  <= re1_aq;
            re2_neg <= re1_neg;
        end
    end

    // E3: angle in Q30 radians.
    logic           re3_v;
    logic [T_W-1:0] re3_t;
    logic [E_W-1:0] re3_e;
    logic           re3_neg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            re3_t   <= T_W'(re2_aq) + T_W'(re2_tp[AR_W+ANGM_W-1:ANG_S]);
            re3_e   <= re2_e;
            re3_neg <= re2_neg;
        end
    end

    // E4: angle squared.
    logic             re4_v;
    logic [2*T_W-1:0] re4_tsq;
    logic [E_W-1:0]   re4_e;
    logic             re4_neg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            re4_tsq <= re3_t * re3_t;
            re4_e   <= re3_e;
            re4_neg <= re3_neg;
        end
    end

    // Cosine series chain, Horner form from the highest term down.
    logic           cs_v    [COS_CELLS+1];
    logic [R_W-1:0] cs_r    [COS_CELLS+1];
    t_cos_side      cs_side [COS_CELLS+1];

    assign cs_v[0]         = re4_v;
    assign cs_r[0]         = R_W'(ONE_Q30);
    assign cs_side[0].neg  = re4_neg;
    assign cs_side[0].e    = re4_e;
    assign cs_side[0].t2   = re4_tsq[T2_W+29:30];

    for (genvar g = 0; g < COS_CELLS; g++) begin : g_cos
        rwsp_cos_cell #(.K(COS_DIVS[g])) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cs_v[g]),
            .i_r     (cs_r[g]),
            .i_side  (cs_side[g]),
            .o_valid (cs_v[g+1]),
            .o_r     (cs_r[g+1]),
            .o_side  (cs_side[g+1])
        );
    end

    // D1: distance times cosine.
    logic               rd1_v;
    logic [E_W+R_W-1:0] rd1_p;
    logic               rd1_neg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            rd1_p   <= cs_side[COS_CELLS].e * cs_r[COS_CELLS];
            rd1_neg <= cs_side[COS_CELLS].neg;
        end
    end

    // D2: corrected distance, forced to at least one LSB and saturated.
    logic              rd2_v;
    logic [DIST_W-1:0] rd2_dist;
    logic [E_W:0]      n_draw;

    assign n_draw = rd1_neg ? '0 : rd1_p[E_W+R_W-1:30];

    always_ff @(posedge i_clk) begin
        if (en) begin
            priority if (n_draw == '0) begin
                rd2_dist <= DIST_W'(1);
            end else if (n_draw > (E_W+1)'({DIST_W{1'b1}})) begin
                rd2_dist <= '1;
            end else begin
                rd2_dist <= DIST_W'(n_draw);
            end
        end
    end

    // Valid bits of the stages above.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            re1_v <= 1'b0;
            re2_v <= 1'b0;
            re3_v <= 1'b0;
            re4_v <= 1'b0;
            rd1_v <= 1'b0;
            rd2_v <= 1'b0;
        end else if (en) begin
            r1_v  <= i_item.valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            re1_v <= sq_v[SQ_CELLS];
            re2_v <= re1_v;
            re3_v <= re2_v;
            re4_v <= re3_v;
            rd1_v <= cs_v[COS_CELLS];
            rd2_v <= rd1_v;
        end
    end

    // Slice height divider chain: (screen_height << DIST_FRAC_BITS) / distance.
    logic              dv_v   [NUM_W+1];
    logic [NUM_W-1:0]  dv_num [NUM_W+1];
    logic [DIST_W-1:0] dv_rem [NUM_W+1];
    logic [NUM_W-1:0]  dv_q   [NUM_W+1];
    logic [DIST_W-1:0] dv_d   [NUM_W+1];

    assign dv_v[0]   = rd2_v;
    assign dv_num[0] = {r_screen_height, DIST_FRAC_BITS'(0)};
    assign dv_rem[0] = '0;
    assign dv_q[0]   = '0;
    assign dv_d[0]   = rd2_dist;

    for (genvar g = 0; g < NUM_W; g++) begin : g_div
        rwsp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[g]),
            .i_num   (dv_num[g]),
            .i_rem   (dv_rem[g]),
            .i_q     (dv_q[g]),
            .i_d     (dv_d[g]),
            .o_valid (dv_v[g+1]),
            .o_num   (dv_num[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_q     (dv_q[g+1]),
            .o_d     (dv_d[g+1])
        );
    end

    // Row placement around the middle row.
    logic [H_W-1:0]  n_h;
    logic [H_W-1:0]  n_up;
    logic [H_W-1:0]  n_dn;
    logic [SH_W-2:0] n_half;
    logic [H_W:0]    n_bot;
    logic [SH_W-1:0] n_lim;
    t_result         n_res;

    assign n_h    = H_W'(dv_q[NUM_W]);
    assign n_up   = H_W'((21'(n_h) + 21'd1) >> 1);
    assign n_dn   = n_h >> 1;
    assign n_half = r_screen_height[SH_W-1:1];
    assign n_bot  = (H_W+1)'(n_half) + (H_W+1)'(n_dn);
    assign n_lim  = (r_screen_height != '0) ? (r_screen_height - SH_W'(1)) : '0;

    always_comb begin
        n_res.corrected_distance = dv_d[NUM_W];
        n_res.slice_height       = n_h;
        n_res.top_row            = (H_W'(n_half) > n_up) ? ROW_W'(H_W'(n_half) - n_up) : '0;
        n_res.bottom_row         = (n_bot > (H_W+1)'(n_lim)) ? ROW_W'(n_lim) : ROW_W'(n_bot);
    end

    // Output register with one skid entry behind it.
    t_result r_out;
    logic    r_out_v;
    t_result r_skid;
    logic    r_skid_v;
    logic    take;
    logic    arrive;

    assign en     = !r_skid_v;
    assign take   = r_out_v && o_result.ready;
    assign arrive = dv_v[NUM_W] && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (arrive) begin
            if (!r_out_v || take) begin
                r_out   <= n_res;
                r_out_v <= 1'b1;
            end else begin
                r_skid   <= n_res;
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_result.valid = r_out_v;
    assign o_result.data  = r_out;
endmodule

// ===== tb/sv/tb_raycast_wall_slice_projection.sv =====
`timescale 1ns / 1ps

module tb_raycast_wall_slice_projection;
    import rwsp_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rwsp_stream_if #(.T(t_item))          item_if ();
    rwsp_stream_if #(.T(logic [SH_W-1:0])) cfg_if ();
    rwsp_stream_if #(.T(t_result))        res_if ();

    raycast_wall_slice_projection dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if.sink),
        .i_cfg    (cfg_if.sink),
        .o_result (res_if.source)
    );

    // Columns waiting to be sent and projections waiting to come back.
    t_item   column_q[$];
    t_result projection_q[$];
    logic [SH_W-1:0] rows_now = 12'd1080;

    int  mismatches = 0;
    bit  no_idle = 1'b0;      // Last part of the run drives and takes at full rate.
    bit  hold_sink = 1'b0;    // Long receiver hold-off, timed in the main test sequence.
    bit  item_taken = 1'b0;   // An input transfer happened at the last rising edge.
    int  send_gap = 0;
    int  take_gap = 0;

    // Integer square root of a 64-bit value, bit by bit.
    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Cosine of an angle within one quarter turn, Q30, by a truncated Taylor series.
    function automatic longint quarter_cosine(input longint a);
        longint unsigned t;
        longint t2, r;
        int k[5];
        k = '{90, 56, 30, 12, 2};
        t = (longint'(a) * 64'd3373259426) / HALF_TURN;
        t2 = longint'((t * t) >> 30);
        r = ONE_Q30;
        for (int i = 0; i < 5; i++) r = ONE_Q30 - ((r * t2) / ONE_Q30) / k[i];
        if (r < 0) r = 0;
        if (r > ONE_Q30) r = ONE_Q30;
        return r;
    endfunction

    function automatic t_result project_column(input t_item c, input logic [SH_W-1:0] rows);
        t_result o;
        longint dx, dy, m, cs;
        longint unsigned sum, raw, eu, cdist, h, half, top, bot, lim, sh;
        dx = longint'(c.viewer_x) - longint'(c.hit_x);
        dy = longint'(c.viewer_y) - longint'(c.hit_y);
        sum = dx * dx + dy * dy;
        raw = isqrt(sum << 16);
        eu = (raw << DIST_FRAC_BITS) / (TILE_SIZE * 256);
        m = (longint'(c.column_angle) - longint'(c.view_angle)) % FULL_TURN;
        if (m < 0) m += FULL_TURN;
        if (m <= QUARTER_TURN) cs = quarter_cosine(m);
        else if (m < HALF_TURN) cs = -quarter_cosine(HALF_TURN - m);
        else if (m <= HALF_TURN + QUARTER_TURN) cs = -quarter_cosine(m - HALF_TURN);
        else cs = quarter_cosine(FULL_TURN - m);
        cdist = (cs > 0) ? ((eu * longint'(cs)) >> 30) : 0;
        if (cdist == 0) cdist = 1;
        if (cdist > 16'hFFFF) cdist = 16'hFFFF;
        sh = rows;
        h = (sh << DIST_FRAC_BITS) / cdist;
        if (h > 20'hFFFFF) h = 20'hFFFFF;
        half = sh >> 1;
        top = (half > (h + 1) / 2) ? half - (h + 1) / 2 : 0;
        bot = half + h / 2;
        lim = (sh > 0) ? sh - 1 : 0;
        if (bot > lim) bot = lim;
        o.corrected_distance = cdist[15:0];
        o.slice_height = h[19:0];
        o.top_row = top[11:0];
        o.bottom_row = bot[11:0];
        return o;
    endfunction

    // Input transfers are seen at the rising edge, where they happen.
    always @(posedge i_clk) begin
        item_taken <= i_rst_n && item_if.valid && item_if.ready;
    end

    // Driver: offers the head of the queue, with random idle bursts between transfers.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else begin
            if (item_taken) begin
                projection_q.push_back(project_column(column_q.pop_front(), rows_now));
                if (!no_idle && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 7);
            end
            if (send_gap > 0) begin
                send_gap--;
                item_if.valid <= 1'b0;
            end else if (column_q.size() > 0) begin
                item_if.valid <= 1'b1;
                item_if.data <= column_q[0];
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // Receiver ready, with idle bursts and the long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_sink) begin
            res_if.ready <= 1'b0;
        end else if (take_gap > 0) begin
            take_gap--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 5) == 0) take_gap = $urandom_range(1, 7);
        end
    end

    // Monitor: each result transfer is checked against the oldest projection.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (projection_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", res_if.data);
            end else begin
                want = projection_q.pop_front();
                if (res_if.data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, got %p", want, res_if.data);
                end
            end
        end
    end

    function automatic t_item random_column();
        t_item c;
        int r;
        c.viewer_x = $urandom;
        c.viewer_y = $urandom;
        r = $urandom_range(0, 3);
        // Mostly nearby hits, so the slice heights land across the whole screen.
        if (r == 0) begin
            c.hit_x = $urandom;
            c.hit_y = $urandom;
        end else begin
            c.hit_x = c.viewer_x + 16'($urandom_range(0, 2000)) - 16'd1000;
            c.hit_y = c.viewer_y + 16'($urandom_range(0, 2000)) - 16'd1000;
        end
        c.view_angle = $urandom;
        if ($urandom_range(0, 3) == 0) c.column_angle = $urandom;
        else c.column_angle = c.view_angle + 16'($urandom_range(0, 4000)) - 16'd2000;
        return c;
    endfunction

    task automatic add_column(input logic [15:0] vx, vy, hx, hy, ca, va);
        t_item c;
        c.viewer_x = vx; c.viewer_y = vy; c.hit_x = hx; c.hit_y = hy;
        c.column_angle = ca; c.view_angle = va;
        column_q.push_back(c);
    endtask

    task automatic wait_drained();
        while (column_q.size() > 0 || item_if.valid || projection_q.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // Screen height is written only while the pipeline is empty.
    task automatic set_rows(input logic [SH_W-1:0] v);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        rows_now = v;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        logic [SH_W-1:0] heights[6];
        item_if.valid = 1'b0;
        item_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        res_if.ready = 1'b0;
        heights = '{12'd4095, 12'd1, 12'd480, 12'd2, 12'd1080, 12'd3000};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed columns at the reset height: coincident points, extremes,
        // right angle and beyond, and angles that wrap around a full turn.
        add_column(16'd100, 16'd100, 16'd100, 16'd100, 16'd0, 16'd0);
        add_column(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        add_column(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'h7FFF, 16'h8000);
        add_column(16'd0, 16'd0, 16'd90, 16'd0, 16'd5760, 16'd0);
        add_column(16'd0, 16'd0, 16'd90, 16'd0, 16'd5759, 16'd0);
        add_column(16'd0, 16'd0, 16'd900, 16'd0, 16'd11520, 16'd0);
        add_column(16'd0, 16'd0, 16'd900, 16'd0, -16'sd23040, 16'd23039);
        add_column(16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
        add_column(16'd50, 16'd50, 16'd50, 16'd51, 16'd100, -16'sd100);
        add_column(16'd0, 16'd0, 16'd9000, 16'd9000, 16'd17280, 16'd0);
        add_column(16'd500, 16'd0, 16'd0, 16'd0, 16'd23039, -16'sd23040);
        add_column(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        wait_drained();

        // Each screen height gets a phase of random columns.
        for (int p = 0; p < 6; p++) begin
            set_rows(heights[p]);
            if (p == 5) no_idle = 1'b1;
            for (int i = 0; i < 120; i++) column_q.push_back(random_column());
            if (p == 2) begin
                // Hold results back long enough to fill the pipeline and its buffer.
                hold_sink = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            wait_drained();
        end
        set_rows(12'd0);
        for (int i = 0; i < 20; i++) column_q.push_back(random_column());
        wait_drained();

        if (mismatches == 0) begin
            $display("raycast_wall_slice_projection: match");
        end else begin
            $display("raycast_wall_slice_projection: mismatch");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("raycast_wall_slice_projection: mismatch");
        $finish;
    end

endmodule
